// File: design/rau_pkg.sv
// Package for the rational arithmetic unit: command, status and order codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
package rau_pkg;

	localparam int OPERAND_WIDTH_DEF = 32;
	localparam int FIELD_W = 32;
	localparam int WORD_W = 64;

	localparam logic [2:0] CMD_ADD = 3'd0;
	localparam logic [2:0] CMD_SUB = 3'd1;
	localparam logic [2:0] CMD_MUL = 3'd2;
	localparam logic [2:0] CMD_DIV = 3'd3;
	localparam logic [2:0] CMD_CMP = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ZERO_DEN = 2'd1;
	localparam logic [1:0] ST_DIV_ZERO = 2'd2;

	localparam logic [1:0] ORD_LESS = 2'd0;
	localparam logic [1:0] ORD_EQUAL = 2'd1;
	localparam logic [1:0] ORD_GREATER = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_GCD_INIT,
		S_GCD,
		S_DIV_INIT,
		S_DIV,
		S_WB,
		S_MUL,
		S_COMB,
		S_DIVZ,
		S_FIN
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_GCD_INIT,
		OP_GCD_STEP,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_WB,
		OP_MUL,
		OP_COMB,
		OP_DIVZ,
		OP_OUT_LOAD
	} op_t;

	typedef enum logic [1:0] {
		SEL_LEFT,
		SEL_RIGHT,
		SEL_QUOT,
		SEL_RES
	} sel_t;

	typedef struct packed {
		op_t  op;
		sel_t sel;
	} ctrl_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       zero_den;
		logic       gcd_done;
		logic       div_done;
		logic       rn_zero;
		logic       out_free;
	} stat_t;

endpackage

// File: design/rau_req_if.sv
// Request channel of the rational arithmetic unit: command and two fractions.
// Depends on rau_pkg for the field width.
`timescale 1ns / 1ps
interface rau_req_if
	import rau_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic [2:0]                command;
	logic signed [FIELD_W-1:0] left_num;
	logic signed [FIELD_W-1:0] left_den;
	logic signed [FIELD_W-1:0] right_num;
	logic signed [FIELD_W-1:0] right_den;

	modport source (output valid, command, left_num, left_den, right_num, right_den,
		input ready);
	modport sink (input valid, command, left_num, left_den, right_num, right_den,
		output ready);
endinterface

// File: design/rau_rsp_if.sv
// Response channel of the rational arithmetic unit: reduced fraction, order, status.
// Depends on rau_pkg for the word width.
`timescale 1ns / 1ps
interface rau_rsp_if
	import rau_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] result_num;
	logic [WORD_W-2:0]        result_den;
	logic [1:0]               order;
	logic [1:0]               status;

	modport source (output valid, result_num, result_den, order, status, input ready);
	modport sink (input valid, result_num, result_den, order, status, output ready);
endinterface

// File: design/rau_ctrl.sv
// Controller of the rational arithmetic unit: sequences operand reduction,
// multiplication, combination and result reduction. Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_ctrl
	import rau_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output ctrl_t ctrl
);

	state_t state_q, state_d;
	sel_t   sel_q, sel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q <= SEL_LEFT;
		end else begin
			state_q <= state_d;
			sel_q <= sel_d;
		end
	end

	always_comb begin
		state_d = state_q;
		sel_d = sel_q;
		ctrl.op = OP_NONE;
		ctrl.sel = sel_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.op = OP_LOAD;
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				if (stat.zero_den) begin
					state_d = S_FIN;
				end else begin
					sel_d = SEL_LEFT;
					state_d = S_GCD_INIT;
				end
			end
			S_GCD_INIT: begin
				ctrl.op = OP_GCD_INIT;
				state_d = S_GCD;
			end
			S_GCD: begin
				ctrl.op = OP_GCD_STEP;
				if (stat.gcd_done) state_d = S_DIV_INIT;
			end
			S_DIV_INIT: begin
				ctrl.op = OP_DIV_INIT;
				state_d = S_DIV;
			end
			S_DIV: begin
				ctrl.op = OP_DIV_STEP;
				if (stat.div_done) state_d = S_WB;
			end
			S_WB: begin
				ctrl.op = OP_WB;
				unique case (sel_q)
					SEL_LEFT: begin
						sel_d = SEL_RIGHT;
						state_d = S_GCD_INIT;
					end
					SEL_RIGHT: begin
						// The right operand is only final after this write, so the
						// zero check for divide is made afterwards in the multiply state.
						if (stat.cmd == CMD_DIV || stat.cmd == CMD_ADD || stat.cmd == CMD_SUB
							|| stat.cmd == CMD_MUL || stat.cmd == CMD_CMP) begin
							state_d = S_MUL;
						end else begin
							state_d = S_FIN;
						end
					end
					SEL_QUOT: state_d = S_MUL;
					SEL_RES:  state_d = S_FIN;
					default:  state_d = S_FIN;
				endcase
			end
			S_MUL: begin
				if (stat.cmd == CMD_DIV && sel_q == SEL_RIGHT) begin
					if (stat.rn_zero) begin
						state_d = S_DIVZ;
					end else begin
						sel_d = SEL_QUOT;
						state_d = S_GCD_INIT;
					end
				end else begin
					ctrl.op = OP_MUL;
					state_d = S_COMB;
				end
			end
			S_COMB: begin
				ctrl.op = OP_COMB;
				if (stat.cmd == CMD_CMP) begin
					state_d = S_FIN;
				end else begin
					sel_d = SEL_RES;
					state_d = S_GCD_INIT;
				end
			end
			S_DIVZ: begin
				ctrl.op = OP_DIVZ;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (stat.out_free) begin
					ctrl.op = OP_OUT_LOAD;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// File: design/rau_datapath.sv
// Datapath of the rational arithmetic unit: operand registers, binary GCD,
// two radix-2 dividers sharing one divisor, multipliers and the output register.
// Depends on rau_pkg and the request/response interfaces.
`timescale 1ns / 1ps
module rau_datapath
	import rau_pkg::*;
#(
	parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rau_req_if.sink   req,
	rau_rsp_if.source rsp,
	input  ctrl_t     ctrl,
	output stat_t     stat
);

	localparam int W = OPERAND_WIDTH;
	// Reduced operands reach magnitude 2**(W-1), so multiplier inputs need one spare bit.
	localparam int MW = W + 1;

	logic [2:0]               cmd_q;
	logic signed [WORD_W-1:0] ln_q, ld_q, rn_q, rd_q, n_q, d_q;
	logic [WORD_W-1:0]        a_q, b_q, g_q, qn_q, qd_q;
	logic [6:0]               k_q, cnt_q;
	logic                     neg_q;
	logic [WORD_W:0]          rem_n_q, rem_d_q;
	logic signed [WORD_W-1:0] p1_s1, p2_s1, p3_s1, p4_s1;
	logic [1:0]               order_q, status_q;
	logic                     out_valid_q;
	logic signed [WORD_W-1:0] out_num_q;
	logic [WORD_W-2:0]        out_den_q;
	logic [1:0]               out_order_q, out_status_q;

	logic signed [WORD_W-1:0] ln_x, ld_x, rn_x, rd_x, red_n, red_d;
	logic signed [MW-1:0]     ln_m, ld_m, rn_m, rd_m;
	logic [WORD_W:0]          tn, td, gx;
	logic [WORD_W-1:0]        nq;

	function automatic logic signed [WORD_W-1:0] sext(input logic [FIELD_W-1:0] raw);
		return {{(WORD_W - W){raw[W-1]}}, raw[W-1:0]};
	endfunction

	function automatic logic [WORD_W-1:0] mag(input logic signed [WORD_W-1:0] v);
		return v[WORD_W-1] ? WORD_W'(-v) : WORD_W'(v);
	endfunction

	assign ln_x = sext(req.left_num);
	assign ld_x = sext(req.left_den);
	assign rn_x = sext(req.right_num);
	assign rd_x = sext(req.right_den);

	assign ln_m = ln_q[MW-1:0];
	assign ld_m = ld_q[MW-1:0];
	assign rn_m = rn_q[MW-1:0];
	assign rd_m = rd_q[MW-1:0];

	always_comb begin
		case (ctrl.sel)
			SEL_LEFT: begin
				red_n = ln_q;
				red_d = ld_q;
			end
			SEL_RIGHT: begin
				red_n = rn_q;
				red_d = rd_q;
			end
			SEL_QUOT: begin
				red_n = rd_q;
				red_d = rn_q;
			end
			default: begin
				red_n = n_q;
				red_d = d_q;
			end
		endcase
	end

	assign gx = {1'b0, g_q};
	assign tn = {rem_n_q[WORD_W-1:0], qn_q[WORD_W-1]};
	assign td = {rem_d_q[WORD_W-1:0], qd_q[WORD_W-1]};
	assign nq = neg_q ? WORD_W'(-qn_q) : qn_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				cmd_q <= req.command;
				ln_q <= ln_x;
				ld_q <= ld_x;
				rn_q <= rn_x;
				rd_q <= rd_x;
				n_q <= '0;
				d_q <= WORD_W'(1);
				order_q <= ORD_LESS;
				status_q <= (ld_x == '0 || rd_x == '0) ? ST_ZERO_DEN : ST_OK;
			end
			OP_GCD_INIT: begin
				a_q <= mag(red_n);
				b_q <= mag(red_d);
				qn_q <= mag(red_n);
				qd_q <= mag(red_d);
				k_q <= '0;
				neg_q <= red_n[WORD_W-1] ^ red_d[WORD_W-1];
			end
			OP_GCD_STEP: begin
				if (a_q != '0 && b_q != '0) begin
					if (!a_q[0] && !b_q[0]) begin
						a_q <= a_q >> 1;
						b_q <= b_q >> 1;
						k_q <= k_q + 7'd1;
					end else if (!a_q[0]) begin
						a_q <= a_q >> 1;
					end else if (!b_q[0]) begin
						b_q <= b_q >> 1;
					end else if (a_q >= b_q) begin
						a_q <= a_q - b_q;
					end else begin
						b_q <= b_q - a_q;
					end
				end
			end
			OP_DIV_INIT: begin
				g_q <= (a_q | b_q) << k_q;
				rem_n_q <= '0;
				rem_d_q <= '0;
				cnt_q <= '0;
			end
			OP_DIV_STEP: begin
				if (tn >= gx) begin
					rem_n_q <= tn - gx;
					qn_q <= {qn_q[WORD_W-2:0], 1'b1};
				end else begin
					rem_n_q <= tn;
					qn_q <= {qn_q[WORD_W-2:0], 1'b0};
				end
				if (td >= gx) begin
					rem_d_q <= td - gx;
					qd_q <= {qd_q[WORD_W-2:0], 1'b1};
				end else begin
					rem_d_q <= td;
					qd_q <= {qd_q[WORD_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 7'd1;
			end
			OP_WB: begin
				case (ctrl.sel)
					SEL_LEFT: begin
						ln_q <= nq;
						ld_q <= qd_q;
					end
					SEL_RIGHT, SEL_QUOT: begin
						rn_q <= nq;
						rd_q <= qd_q;
					end
					default: begin
						n_q <= nq;
						d_q <= qd_q;
					end
				endcase
			end
			OP_MUL: begin
				p1_s1 <= WORD_W'(ln_m * rd_m);
				p2_s1 <= WORD_W'(rn_m * ld_m);
				p3_s1 <= WORD_W'(ld_m * rd_m);
				p4_s1 <= WORD_W'(ln_m * rn_m);
			end
			OP_COMB: begin
				case (cmd_q)
					CMD_ADD: begin
						n_q <= p1_s1 + p2_s1;
						d_q <= p3_s1;
					end
					CMD_SUB: begin
						n_q <= p1_s1 - p2_s1;
						d_q <= p3_s1;
					end
					CMD_CMP: begin
						n_q <= '0;
						d_q <= WORD_W'(1);
						if (p1_s1 < p2_s1) order_q <= ORD_LESS;
						else if (p1_s1 == p2_s1) order_q <= ORD_EQUAL;
						else order_q <= ORD_GREATER;
					end
					default: begin
						n_q <= p4_s1;
						d_q <= p3_s1;
					end
				endcase
			end
			OP_DIVZ: status_q <= ST_DIV_ZERO;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.op == OP_OUT_LOAD) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_OUT_LOAD) begin
			out_num_q <= n_q;
			out_den_q <= d_q[WORD_W-2:0];
			out_order_q <= order_q;
			out_status_q <= status_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.result_num = out_num_q;
	assign rsp.result_den = out_den_q;
	assign rsp.order = out_order_q;
	assign rsp.status = out_status_q;

	assign stat.cmd = cmd_q;
	assign stat.zero_den = (status_q == ST_ZERO_DEN);
	assign stat.gcd_done = (a_q == '0) || (b_q == '0);
	assign stat.div_done = (cnt_q == 7'(WORD_W - 1));
	assign stat.rn_zero = (rn_q == '0);
	assign stat.out_free = !out_valid_q || rsp.ready;

endmodule

// File: design/rational_arithmetic_unit.sv
// Rational arithmetic unit: add, subtract, multiply, divide or compare two fractions,
// results reduced by the GCD with a positive denominator. A zero denominator skips the
// arithmetic: the controller goes from its load state straight to the finish state.
// Each reduction runs a binary GCD loop and then divides numerator and denominator by
// the GCD; unused commands and compare need two reductions, add, subtract and multiply
// three, divide four (two when the right numerator is zero). One item is in work at a
// time; the next beat is accepted the cycle after the result enters the output register,
// which it enters only once the previous result has been taken. Asynchronous active-low
// reset empties the controller and the output register.
`timescale 1ns / 1ps
module rational_arithmetic_unit
	import rau_pkg::*;
#(
	parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	rau_req_if.sink   req,
	rau_rsp_if.source rsp
);

	ctrl_t ctrl;
	stat_t stat;

	rau_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	rau_datapath #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.ctrl   (ctrl),
		.stat   (stat)
	);

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the rational arithmetic unit.
// Drives fractions and commands through rau_req_if, checks each rau_rsp_if beat
// against a predictor of reduced results. Depends on rau_pkg and both interfaces.
`timescale 1ns / 1ps
module tb_top;
	import rau_pkg::*;

	typedef struct {
		logic signed [63:0] num;
		logic [62:0]        den;
		logic [1:0]         ord;
		logic [1:0]         st;
	} fraction_result_t;

	localparam longint CYCLE_LIMIT = 64'd12000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	rau_req_if req ();
	rau_rsp_if rsp ();

	rational_arithmetic_unit uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	fraction_result_t pending_results[$];
	int errors = 0;
	bit stall_enable = 1'b1;
	longint cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		req.valid = 1'b0;
		req.command = CMD_ADD;
		req.left_num = '0;
		req.left_den = 32'sd1;
		req.right_num = '0;
		req.right_den = 32'sd1;
		rsp.ready = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 64'sd1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic longint unsigned magnitude(longint v);
		return v < 0 ? 64'd0 - longint'(v) : longint'(v);
	endfunction

	function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
		longint unsigned t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	function automatic void reduce_fraction(inout longint n, inout longint d);
		longint unsigned g;
		g = gcd_of(magnitude(n), magnitude(d));
		if (g > 1) begin
			n = n / longint'(g);
			d = d / longint'(g);
		end
		if (d < 0) begin
			n = -n;
			d = -d;
		end
	endfunction

	function automatic fraction_result_t predict_fraction(logic [2:0] cmd, logic signed [31:0] ln_i,
		logic signed [31:0] ld_i, logic signed [31:0] rn_i, logic signed [31:0] rd_i);
		fraction_result_t r;
		longint ln, ld, rn, rd, n, d, qn, qd, a, b;
		ln = longint'(ln_i);
		ld = longint'(ld_i);
		rn = longint'(rn_i);
		rd = longint'(rd_i);
		n = 64'sd0;
		d = 64'sd1;
		r.ord = ORD_LESS;
		r.st = ST_OK;
		if (ld == 0 || rd == 0) begin
			r.st = ST_ZERO_DEN;
		end else begin
			reduce_fraction(ln, ld);
			reduce_fraction(rn, rd);
			case (cmd)
				CMD_ADD: begin
					n = ln * rd + rn * ld;
					d = ld * rd;
					reduce_fraction(n, d);
				end
				CMD_SUB: begin
					n = ln * rd - rn * ld;
					d = ld * rd;
					reduce_fraction(n, d);
				end
				CMD_MUL: begin
					n = ln * rn;
					d = ld * rd;
					reduce_fraction(n, d);
				end
				CMD_DIV: begin
					if (rn == 0) begin
						r.st = ST_DIV_ZERO;
					end else begin
						qn = rd;
						qd = rn;
						reduce_fraction(qn, qd);
						n = ln * qn;
						d = ld * qd;
						reduce_fraction(n, d);
					end
				end
				CMD_CMP: begin
					a = ln * rd;
					b = rn * ld;
					r.ord = a < b ? ORD_LESS : (a == b ? ORD_EQUAL : ORD_GREATER);
				end
				default: ;
			endcase
		end
		r.num = n;
		r.den = d[62:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("Mismatch on %s: got %0d, expected %0d", what, got, want);
	endtask

	task automatic send_fraction_pair(logic [2:0] cmd, logic signed [31:0] ln,
		logic signed [31:0] ld, logic signed [31:0] rn, logic signed [31:0] rd);
		int gap;
		if (stall_enable && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			gap = $urandom_range(1, 9);
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.command <= cmd;
		req.left_num <= ln;
		req.left_den <= ld;
		req.right_num <= rn;
		req.right_den <= rd;
		pending_results.push_back(predict_fraction(cmd, ln, ld, rn, rd));
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic finish_sending();
		req.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Response side: random ready bursts, and every beat is checked.
	initial begin
		fraction_result_t want;
		int burst;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected beat", 64'sd1, 64'sd0);
				end else begin
					want = pending_results.pop_front();
					if (rsp.result_num !== want.num)
						report_mismatch("result_num", rsp.result_num, want.num);
					if (rsp.result_den !== want.den)
						report_mismatch("result_den", longint'(rsp.result_den),
							longint'(want.den));
					if (rsp.order !== want.ord)
						report_mismatch("order", longint'(rsp.order), longint'(want.ord));
					if (rsp.status !== want.st)
						report_mismatch("status", longint'(rsp.status), longint'(want.st));
				end
			end
			if (stall_enable && rsp.ready && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 9);
				rsp.ready <= 1'b0;
				repeat (burst) @(posedge clk);
				// Beats cannot complete while ready is low, so nothing is missed.
			end
			rsp.ready <= 1'b1;
		end
	end

	function automatic logic signed [31:0] random_operand();
		case ($urandom_range(0, 5))
			0: return $signed($urandom_range(0, 20)) - 32'sd10;
			1: return 32'sh80000000;
			2: return 32'sh7fffffff;
			3: return $signed($urandom_range(0, 2000)) - 32'sd1000;
			default: return $signed($urandom());
		endcase
	endfunction

	task automatic test_extremes();
		logic signed [31:0] edge_vals[6] = '{32'sh80000000, 32'sh7fffffff, -32'sd1, 32'sd1,
			32'sd0, 32'sd6};
		for (int c = 0; c < 5; c++)
			for (int k = 0; k < 3; k++)
				send_fraction_pair(c[2:0], edge_vals[k], edge_vals[k + 1], edge_vals[5 - k],
					edge_vals[k]);
	endtask

	task automatic test_special_cases();
		send_fraction_pair(CMD_ADD, 32'sd3, 32'sd0, 32'sd1, 32'sd2);
		send_fraction_pair(CMD_DIV, 32'sd3, 32'sd4, 32'sd0, 32'sd0);
		send_fraction_pair(CMD_DIV, 32'sd3, 32'sd4, 32'sd0, -32'sd5);
		send_fraction_pair(CMD_CMP, 32'sd2, 32'sd4, -32'sd3, -32'sd6);
		send_fraction_pair(CMD_SUB, 32'sd1, 32'sd2, 32'sd2, 32'sd4);
		send_fraction_pair(3'd5, 32'sd1, 32'sd2, 32'sd1, 32'sd3);
		send_fraction_pair(3'd7, 32'sd1, 32'sd0, 32'sd1, 32'sd3);
	endtask

	task automatic test_random(int count);
		logic [2:0] cmd;
		for (int i = 0; i < count; i++) begin
			cmd = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			send_fraction_pair(cmd, random_operand(), random_operand(), random_operand(),
				random_operand());
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_special_cases();
		test_random(1400);
		// The closing stretch runs without idling on either side.
		stall_enable = 1'b0;
		test_random(200);
		finish_sending();
		wait (pending_results.size() == 0);
		repeat (1000) @(posedge clk);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

// File: rational_arithmetic_unit.f
design/rau_pkg.sv
design/rau_req_if.sv
design/rau_rsp_if.sv
design/rau_ctrl.sv
design/rau_datapath.sv
design/rational_arithmetic_unit.sv
tb/tb_top.sv
